>>> sv/ffda_pkg.sv
// ----------------------------------------------------------------------------
// ffda_pkg: shared types and constants for the float to decimal text block
// Holds field widths, ASCII codes, sequencer states, the control bundles
// between the sequencer and its datapath units, and the power-of-ten table.
// ----------------------------------------------------------------------------
package ffda_pkg;

  localparam int MAX_DIGITS_DEF = 45;

  localparam int FLOAT_W = 32;
  localparam int EXP_W   = 8;
  localparam int FRAC_W  = 23;
  localparam int MANT_W  = FRAC_W + 1;
  localparam int POW_W   = 20;               // holds 10^6
  localparam int PROD_W  = MANT_W + POW_W;   // scaled mantissa
  localparam int SH_W    = 9;                // signed binary exponent of the mantissa
  localparam int ZERO_W  = 7;                // trailing zero bits, at most 104
  localparam int CNT_W   = 8;                // conversion steps, at most 148
  localparam int PREC_W  = 3;
  localparam int CHAR_W  = 8;

  localparam logic [EXP_W-1:0]  EXP_ALL_ONES = 8'hFF;
  localparam logic [SH_W-1:0]   DENORM_SHIFT = 9'h16B;   // -149
  localparam logic [SH_W-1:0]   NORM_OFFSET  = 9'd150;   // bias plus fraction width
  localparam logic [PREC_W-1:0] PREC_RESET   = 3'd3;
  localparam logic [PREC_W-1:0] PREC_MIN     = 3'd1;
  localparam logic [PREC_W-1:0] PREC_MAX     = 3'd6;

  localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
  localparam logic [CHAR_W-1:0] CH_DOT   = 8'h2E;
  localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0] CH_LC_A  = 8'h61;
  localparam logic [CHAR_W-1:0] CH_LC_F  = 8'h66;
  localparam logic [CHAR_W-1:0] CH_LC_I  = 8'h69;
  localparam logic [CHAR_W-1:0] CH_LC_N  = 8'h6E;

  localparam logic [1:0] SPEC_FIRST_SIGNED = 2'd0;
  localparam logic [1:0] SPEC_FIRST        = 2'd1;
  localparam logic [1:0] SPEC_LAST         = 2'd3;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_ALIGN,
    ST_CONV,
    ST_SKIP,
    ST_DIGIT,
    ST_SPEC
  } state_t;

  typedef struct packed {
    logic mul_en;
    logic align_en;
    logic shift_en;
  } scale_ctrl_t;

  typedef struct packed {
    logic clear;
    logic dabble;
    logic bit_in;
    logic digit_shift;
  } bcd_ctrl_t;

  function automatic logic [POW_W-1:0] pow10(input logic [PREC_W-1:0] p);
    logic [POW_W-1:0] v;
    unique case (p)
      3'd1:    v = 20'd10;
      3'd2:    v = 20'd100;
      3'd3:    v = 20'd1000;
      3'd4:    v = 20'd10000;
      3'd5:    v = 20'd100000;
      3'd6:    v = 20'd1000000;
      default: v = 20'd1;
    endcase
    return v;
  endfunction

  // Text of a non-finite value: "-inf" runs from index 0, "inf" and "nan" from 1.
  function automatic logic [CHAR_W-1:0] spec_char(input logic is_nan, input logic [1:0] idx);
    logic [CHAR_W-1:0] c;
    unique case (idx)
      2'd0:    c = CH_MINUS;
      2'd1:    c = is_nan ? CH_LC_N : CH_LC_I;
      2'd2:    c = is_nan ? CH_LC_A : CH_LC_N;
      default: c = is_nan ? CH_LC_N : CH_LC_F;
    endcase
    return c;
  endfunction

endpackage

>>> sv/ffda_scale.sv
// ----------------------------------------------------------------------------
// ffda_scale: mantissa scaling and alignment unit
// Multiplies the mantissa by 10^precision, rounds away the negative binary
// exponent half-up, then shifts the result out MSB first, one bit per beat.
// ----------------------------------------------------------------------------
module ffda_scale (
  input  logic                          clk,
  input  ffda_pkg::scale_ctrl_t         ctrl,
  input  logic [ffda_pkg::FLOAT_W-1:0]  float_bits,
  input  logic [ffda_pkg::PREC_W-1:0]   prec,
  output logic                          msb,
  output logic [ffda_pkg::ZERO_W-1:0]   zeros
);
  import ffda_pkg::*;

  logic [EXP_W-1:0]   exp_f;
  logic [MANT_W-1:0]  mant;
  logic [SH_W-1:0]    sh_c;
  logic [PROD_W-1:0]  prod_c;
  logic [PROD_W-1:0]  prod_r;
  logic [SH_W-1:0]    sh_r;
  logic [PROD_W-1:0]  base_r;
  logic [PROD_W-1:0]  base_nxt;
  logic [SH_W-1:0]    neg_sh;
  logic [CNT_W-1:0]   r_amt;
  logic [PROD_W:0]    half;
  logic [PROD_W:0]    sum;
  logic [PROD_W:0]    shifted;

  assign exp_f  = float_bits[FLOAT_W-2 -: EXP_W];
  assign mant   = (exp_f == '0) ? {1'b0, float_bits[FRAC_W-1:0]}
                                : {1'b1, float_bits[FRAC_W-1:0]};
  assign sh_c   = (exp_f == '0) ? DENORM_SHIFT : ({1'b0, exp_f} - NORM_OFFSET);
  assign prod_c = PROD_W'(mant) * PROD_W'(pow10(prec));

  // Right shift with half-up rounding; anything at or past PROD_W+1 rounds to zero.
  assign neg_sh  = '0 - sh_r;
  assign r_amt   = neg_sh[CNT_W-1:0];
  assign half    = {{PROD_W{1'b0}}, 1'b1} << (r_amt - CNT_W'(1));
  assign sum     = {1'b0, prod_r} + half;
  assign shifted = sum >> r_amt;

  always_comb begin
    if (!sh_r[SH_W-1]) begin
      base_nxt = prod_r;
    end else if (r_amt > CNT_W'(PROD_W)) begin
      base_nxt = '0;
    end else begin
      base_nxt = shifted[PROD_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.mul_en) begin
      prod_r <= prod_c;
      sh_r   <= sh_c;
    end
    if (ctrl.align_en) begin
      base_r <= base_nxt;
    end else if (ctrl.shift_en) begin
      base_r <= {base_r[PROD_W-2:0], 1'b0};
    end
  end

  assign msb   = base_r[PROD_W-1];
  assign zeros = sh_r[SH_W-1] ? '0 : sh_r[ZERO_W-1:0];

endmodule

>>> sv/ffda_bcd.sv
// ----------------------------------------------------------------------------
// ffda_bcd: shift-and-add-3 binary to BCD converter
// Takes one binary bit per beat, MSB first, into a packed BCD register, and
// later hands its digits out from the top one digit per beat.
// ----------------------------------------------------------------------------
module ffda_bcd #(
  parameter int MAX_DIGITS = ffda_pkg::MAX_DIGITS_DEF
) (
  input  logic                clk,
  input  ffda_pkg::bcd_ctrl_t ctrl,
  output logic [3:0]          top_digit
);
  import ffda_pkg::*;

  localparam int BCD_W = 4 * MAX_DIGITS;

  logic [BCD_W-1:0] bcd_r;
  logic [BCD_W-1:0] adj;

  // Each digit of five or more gets three added so the doubling carries in decimal.
  always_comb begin
    for (int i = 0; i < MAX_DIGITS; i++) begin
      if (bcd_r[4*i +: 4] >= 4'd5) begin
        adj[4*i +: 4] = bcd_r[4*i +: 4] + 4'd3;
      end else begin
        adj[4*i +: 4] = bcd_r[4*i +: 4];
      end
    end
  end

  always_ff @(posedge clk) begin
    priority if (ctrl.clear) begin
      bcd_r <= '0;
    end else if (ctrl.dabble) begin
      bcd_r <= {adj[BCD_W-2:0], ctrl.bit_in};
    end else if (ctrl.digit_shift) begin
      bcd_r <= {bcd_r[BCD_W-5:0], 4'd0};
    end
  end

  assign top_digit = bcd_r[BCD_W-1 -: 4];

endmodule

>>> sv/float_to_fixed_decimal_ascii.sv
// ----------------------------------------------------------------------------
// float_to_fixed_decimal_ascii: binary32 value to fixed-point decimal text
// A leading '-' is registered out from the multiply state; digits follow the
//   align state, the bit-serial BCD conversion loop, which also runs over Z
//   trailing zero bits (Z is the biased exponent minus 150, or 0 when that is
//   negative), and the skip of leading zeros in the 45-digit output scan. nan
//   and inf skip the conversion. A new value is taken only once busy has fallen.
//   Busy falls as the last character goes onto the outputs.
// Results cannot be stalled by the receiver. Reset sets precision to 3.
// ----------------------------------------------------------------------------
module float_to_fixed_decimal_ascii #(
  parameter int MAX_DIGITS = ffda_pkg::MAX_DIGITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  output logic                         busy,
  input  logic [ffda_pkg::FLOAT_W-1:0] in_float_bits,
  output logic                         out_valid,
  output logic [ffda_pkg::CHAR_W-1:0]  out_character,
  output logic                         out_last,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [ffda_pkg::PREC_W-1:0]  cfg_precision
);
  import ffda_pkg::*;

  localparam int RW = $clog2(MAX_DIGITS + 1);

  state_t             state_r, state_nxt;
  logic [PREC_W-1:0]  prec_r;
  logic [PREC_W-1:0]  p_r, p_nxt;
  logic [FLOAT_W-1:0] float_r, float_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic [RW-1:0]      rem_r, rem_nxt;
  logic               dot_r, dot_nxt;
  logic [1:0]         idx_r, idx_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [CHAR_W-1:0]  out_char_r, out_char_nxt;
  logic               out_last_r, out_last_nxt;

  scale_ctrl_t        scale_ctrl;
  bcd_ctrl_t          bcd_ctrl;
  logic               msb;
  logic [ZERO_W-1:0]  zeros;
  logic [3:0]         top_digit;

  logic               prec_ok;
  logic               in_sign, in_frac_zero, in_special;
  logic               cur_sign, cur_nan;
  logic               skip_zero;
  logic               dot_due;

  assign prec_ok      = (prec_r >= PREC_MIN) && (prec_r <= PREC_MAX);
  assign in_sign      = in_float_bits[FLOAT_W-1];
  assign in_frac_zero = (in_float_bits[FRAC_W-1:0] == '0);
  assign in_special   = (in_float_bits[FLOAT_W-2 -: EXP_W] == EXP_ALL_ONES);
  assign cur_sign     = float_r[FLOAT_W-1];
  assign cur_nan      = (float_r[FRAC_W-1:0] != '0);

  // Leading zeros are dropped while more than precision+1 digits remain.
  assign skip_zero = (top_digit == 4'd0) && (rem_r > (RW'(p_r) + RW'(1)));
  assign dot_due   = (rem_r == RW'(p_r)) && !dot_r;

  ffda_scale u_scale (
    .clk        (clk),
    .ctrl       (scale_ctrl),
    .float_bits (float_r),
    .prec       (p_r),
    .msb        (msb),
    .zeros      (zeros)
  );

  ffda_bcd #(
    .MAX_DIGITS (MAX_DIGITS)
  ) u_bcd (
    .clk       (clk),
    .ctrl      (bcd_ctrl),
    .top_digit (top_digit)
  );

  always_comb begin
    state_nxt = state_r;
    p_nxt     = p_r;
    float_nxt = float_r;
    cnt_nxt   = cnt_r;
    rem_nxt   = rem_r;
    dot_nxt   = dot_r;
    idx_nxt   = idx_r;
    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          p_nxt     = prec_r;
          float_nxt = in_float_bits;
          if (prec_ok) begin
            if (in_special) begin
              state_nxt = ST_SPEC;
              idx_nxt   = (in_frac_zero && in_sign) ? SPEC_FIRST_SIGNED : SPEC_FIRST;
            end else begin
              state_nxt = ST_MUL;
            end
          end
        end
      end
      ST_MUL: begin
        state_nxt = ST_ALIGN;
      end
      ST_ALIGN: begin
        cnt_nxt   = CNT_W'(PROD_W) + CNT_W'(zeros);
        state_nxt = ST_CONV;
      end
      ST_CONV: begin
        cnt_nxt = cnt_r - CNT_W'(1);
        if (cnt_r == CNT_W'(1)) begin
          state_nxt = ST_SKIP;
          rem_nxt   = RW'(MAX_DIGITS);
          dot_nxt   = 1'b0;
        end
      end
      ST_SKIP: begin
        if (skip_zero) begin
          rem_nxt = rem_r - RW'(1);
        end else begin
          state_nxt = ST_DIGIT;
        end
      end
      ST_DIGIT: begin
        if (dot_due) begin
          dot_nxt = 1'b1;
        end else begin
          rem_nxt = rem_r - RW'(1);
          if (rem_r == RW'(1)) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      ST_SPEC: begin
        idx_nxt = idx_r + 2'd1;
        if (idx_r == SPEC_LAST) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = 1'b0;
    out_char_nxt  = CH_ZERO;
    out_last_nxt  = 1'b0;
    scale_ctrl    = '0;
    bcd_ctrl      = '0;
    unique case (state_r)
      ST_MUL: begin
        scale_ctrl.mul_en = 1'b1;
        bcd_ctrl.clear    = 1'b1;
        if (cur_sign) begin
          out_valid_nxt = 1'b1;
          out_char_nxt  = CH_MINUS;
        end
      end
      ST_ALIGN: begin
        scale_ctrl.align_en = 1'b1;
      end
      ST_CONV: begin
        scale_ctrl.shift_en = 1'b1;
        bcd_ctrl.dabble     = 1'b1;
        bcd_ctrl.bit_in     = msb;
      end
      ST_SKIP: begin
        bcd_ctrl.digit_shift = skip_zero;
      end
      ST_DIGIT: begin
        out_valid_nxt = 1'b1;
        if (dot_due) begin
          out_char_nxt = CH_DOT;
        end else begin
          out_char_nxt         = CH_ZERO | {4'd0, top_digit};
          out_last_nxt         = (rem_r == RW'(1));
          bcd_ctrl.digit_shift = 1'b1;
        end
      end
      ST_SPEC: begin
        out_valid_nxt = 1'b1;
        out_char_nxt  = spec_char(cur_nan, idx_r);
        out_last_nxt  = (idx_r == SPEC_LAST);
      end
      default: begin
        out_valid_nxt = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      prec_r      <= PREC_RESET;
      cnt_r       <= '0;
      rem_r       <= '0;
      dot_r       <= 1'b0;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      rem_r       <= rem_nxt;
      dot_r       <= dot_nxt;
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        prec_r <= cfg_precision;
      end
    end
  end

  always_ff @(posedge clk) begin
    p_r        <= p_nxt;
    float_r    <= float_nxt;
    out_char_r <= out_char_nxt;
    out_last_r <= out_last_nxt;
  end

  assign busy          = (state_r != ST_IDLE);
  assign cfg_ready     = 1'b1;
  assign out_valid     = out_valid_r;
  assign out_character = out_char_r;
  assign out_last      = out_last_r;

  // A start beat while idle with a usable precision always starts a sequence.
  a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && prec_r >= PREC_MIN && prec_r <= PREC_MAX) |=> busy)
    else $error("accepted value did not start a sequence");

  // The final character is never directly followed by another one.
  a_last_gap: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_last) |=> !out_valid)
    else $error("character emitted right after the final one");

  a_conv_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_CONV) |-> (cnt_r != '0))
    else $error("conversion step counter underflow");

  a_digit_rem: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DIGIT) |-> (rem_r != '0))
    else $error("digit output with no digits remaining");

endmodule

>>> dv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: float to fixed-point decimal text testbench
// Sends binary32 patterns under every precision setting, predicts the text of
// each value with an exact wide-integer formatter, and compares every output
// beat, character and last flag, against the oldest expected character.
// ----------------------------------------------------------------------------
module tb_top;
  import ffda_pkg::*;

  localparam int NORM_SHIFT      = 150;     // exponent bias plus fraction width
  localparam int SUBNORMAL_SHIFT = -149;
  localparam int DIGIT_CAP       = 45;
  localparam int SETTLE_CYCLES   = 260;     // longer than the slowest conversion
  localparam int CYCLE_LIMIT     = 800000;
  localparam int PRINT_CAP       = 100;

  localparam logic [FLOAT_W-1:0] DIRECTED_VALUES [20] = '{
    32'h0000_0000,   // +0
    32'h8000_0000,   // -0
    32'h3F80_0000,   // 1.0
    32'hBF80_0000,   // -1.0
    32'h3D80_0000,   // 0.0625, an exact tie at three digits
    32'h3F7F_FFFF,   // just below one, rounds up into the integer digit
    32'h42F6_E979,   // 123.456
    32'h501502F9,    // 1e10
    32'h0000_0001,   // smallest subnormal
    32'h807F_FFFF,   // largest negative subnormal
    32'h0080_0000,   // smallest normal
    32'h3A83_126F,   // 0.001
    32'hB9C4_9BA6,   // negative value that rounds to zero
    32'h7F7F_FFFF,   // largest finite
    32'hFF7F_FFFF,   // most negative finite
    32'h7F80_0000,   // +inf
    32'hFF80_0000,   // -inf
    32'h7FC0_0000,   // quiet nan
    32'hFF80_0001,   // negative nan with the smallest fraction
    32'h4B7F_FFFF    // largest odd integer near 2^24
  };

  typedef struct packed {
    logic [CHAR_W-1:0] ch;
    logic              last;
  } text_beat_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 start = 1'b0;
  logic                 busy;
  logic [FLOAT_W-1:0]   in_float_bits = '0;
  logic                 out_valid;
  logic [CHAR_W-1:0]    out_character;
  logic                 out_last;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [PREC_W-1:0]    cfg_precision = '0;

  text_beat_t           text_q [$];
  logic [PREC_W-1:0]    prec_model;
  bit                   idle_on;
  int                   mismatches = 0;
  int                   cycles = 0;

  float_to_fixed_decimal_ascii DUT (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .in_float_bits (in_float_bits),
    .out_valid     (out_valid),
    .out_character (out_character),
    .out_last      (out_last),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_precision (cfg_precision)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d characters outstanding", cycles, text_q.size());
      $display("FAIL");
      $finish;
    end
  end

  task automatic report_mismatch(input string msg);
    // Keep the log readable when the design is badly broken.
    if (mismatches < PRINT_CAP)
      $display("ERROR @%0t: %s", $realtime, msg);
    mismatches++;
  endtask

  // Queues the characters that the value prints under the current precision.
  function automatic void expect_text(input logic [FLOAT_W-1:0] bits);
    logic [CHAR_W-1:0] txt [0:63];
    logic [CHAR_W-1:0] dig [0:63];
    logic [159:0]      mag;
    logic [159:0]      rem;
    logic [63:0]       prod;
    logic [63:0]       scale;
    logic [EXP_W-1:0]  ex;
    logic [FRAC_W-1:0] fr;
    logic [MANT_W-1:0] mant;
    text_beat_t        beat;
    int                n;
    int                cnt;
    int                sh;
    int                r;
    int                p;
    n = 0;
    cnt = 0;
    p = int'(prec_model);
    ex = bits[30:23];
    fr = bits[22:0];
    if (prec_model < PREC_MIN || prec_model > PREC_MAX)
      return;
    if (ex == EXP_ALL_ONES) begin
      if (fr != '0) begin
        txt[0] = CH_LC_N; txt[1] = CH_LC_A; txt[2] = CH_LC_N;
        n = 3;
      end else begin
        if (bits[31]) begin
          txt[n] = CH_MINUS;
          n++;
        end
        txt[n] = CH_LC_I; txt[n+1] = CH_LC_N; txt[n+2] = CH_LC_F;
        n += 3;
      end
    end else begin
      if (bits[31]) begin
        txt[n] = CH_MINUS;
        n++;
      end
      if (ex == '0) begin
        mant = {1'b0, fr};
        sh = SUBNORMAL_SHIFT;
      end else begin
        mant = {1'b1, fr};
        sh = int'(ex) - NORM_SHIFT;
      end
      scale = 64'd1;
      repeat (p) scale = scale * 64'd10;
      prod = 64'(mant) * scale;
      if (sh < 0) begin
        r = -sh;
        // Round half up while shifting the fraction bits out.
        if (r >= 64)
          prod = '0;
        else
          prod = (prod + (64'd1 << (r - 1))) >> r;
        mag = 160'(prod);
      end else begin
        mag = 160'(prod) << sh;
      end
      do begin
        rem = mag % 160'd10;
        dig[cnt] = CH_ZERO + rem[7:0];
        mag = mag / 160'd10;
        cnt++;
      end while (mag != '0 && cnt < DIGIT_CAP);
      while (cnt <= p) begin
        dig[cnt] = CH_ZERO;
        cnt++;
      end
      while (cnt > 0) begin
        if (cnt == p) begin
          txt[n] = CH_DOT;
          n++;
        end
        cnt--;
        txt[n] = dig[cnt];
        n++;
      end
    end
    for (int k = 0; k < n; k++) begin
      beat.ch = txt[k];
      beat.last = (k == n - 1);
      text_q.push_back(beat);
    end
  endfunction

  always @(posedge clk) begin : check_text
    text_beat_t want;
    if (rst_n && out_valid) begin
      if (text_q.size() == 0) begin
        report_mismatch($sformatf("unexpected character %h last %b", out_character, out_last));
      end else begin
        want = text_q.pop_front();
        if (out_character !== want.ch)
          report_mismatch($sformatf("character %h, expected %h", out_character, want.ch));
        if (out_last !== want.last)
          report_mismatch($sformatf("last %b on character %h, expected %b",
                                    out_last, out_character, want.last));
      end
    end
  end

  // Sends one value; start drops after the accepting edge so no beat repeats.
  task automatic send_value(input logic [FLOAT_W-1:0] bits);
    int mode;
    @(posedge clk);
    if (idle_on) begin
      mode = $urandom_range(0, 3);
      if (mode == 1) begin
        repeat ($urandom_range(1, 12)) @(posedge clk);
      end else if (mode == 2) begin
        while (busy) @(posedge clk);
        repeat ($urandom_range(1, 12)) @(posedge clk);
      end
    end
    start <= 1'b1;
    in_float_bits <= bits;
    do @(posedge clk); while (busy);
    expect_text(bits);
    start <= 1'b0;
  endtask

  task automatic write_precision(input logic [PREC_W-1:0] p);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_precision <= p;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    prec_model = p;
  endtask

  // Ignored values leave nothing to wait for, so a fixed settle follows.
  task automatic wait_idle();
    @(posedge clk);
    while (text_q.size() != 0 || busy) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic logic [FLOAT_W-1:0] random_float();
    logic [FLOAT_W-1:0] v;
    logic [31:0]        m;
    int                 kind;
    int                 k;
    int                 msb;
    v = $urandom();
    kind = $urandom_range(0, 9);
    case (kind)
      2, 3, 4: v[30:23] = 8'($urandom_range(110, 160));
      5:       v[30:23] = 8'($urandom_range(0, 3));
      6:       v[30:23] = 8'($urandom_range(200, 254));
      7:       v[30:23] = 8'($urandom_range(60, 109));
      8: begin
        // Small odd integer over a power of two: with the power at precision+1, scaled values land on halves.
        m = $urandom_range(1, 4095) | 32'd1;
        k = $urandom_range(0, 1) ? int'(prec_model) + 1 : $urandom_range(1, 16);
        msb = 0;
        while ((m >> (msb + 1)) != 0) msb++;
        m = m << (23 - msb);
        v[30:23] = 8'(127 + msb - k);
        v[22:0] = m[22:0];
      end
      9: begin
        v[30:23] = EXP_ALL_ONES;
        if ($urandom_range(0, 1) == 1)
          v[22:0] = '0;
      end
      default: ;
    endcase
    return v;
  endfunction

  task automatic test_directed_values();
    foreach (DIRECTED_VALUES[i])
      send_value(DIRECTED_VALUES[i]);
    wait_idle();
  endtask

  task automatic test_precision_extremes();
    write_precision(PREC_MIN);
    send_value(32'h3F7F_FFFF);
    send_value(32'hC2F6_E979);
    wait_idle();
    write_precision(PREC_MAX);
    send_value(32'h7F7F_FFFF);
    send_value(32'h3586_37BD);
    wait_idle();
    // Out-of-range settings: the values start no sequence and print nothing.
    write_precision(3'd0);
    send_value(32'h3F80_0000);
    wait_idle();
    write_precision(3'd7);
    send_value(32'hFF80_0000);
    wait_idle();
  endtask

  task automatic test_random_values();
    logic [PREC_W-1:0] order [$];
    for (int p = 1; p <= 6; p++)
      order.push_back(PREC_W'(p));
    order.shuffle();
    foreach (order[i]) begin
      write_precision(order[i]);
      repeat (60) send_value(random_float());
      wait_idle();
    end
    write_precision(3'd0);
    repeat (4) send_value(random_float());
    wait_idle();
    write_precision(3'd7);
    repeat (4) send_value(random_float());
    wait_idle();
    // Back-to-back values to close the run.
    idle_on = 1'b0;
    write_precision(PREC_W'($urandom_range(1, 6)));
    repeat (50) send_value(random_float());
    wait_idle();
  endtask

  initial begin
    prec_model = PREC_RESET;
    idle_on = 1'b1;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    test_directed_values();
    test_precision_extremes();
    test_random_values();
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
